### sv/dps_pkg.sv
// Shared types and constants of the dynamic priority scheduler.
`default_nettype none

package dps_pkg;

   localparam int ID_W   = 8;
   localparam int RT_W   = 16;
   localparam int PRIO_W = 16;
   localparam int SLOT_W = 4;
   localparam int WAIT_W = 32;

   // request word: proc_id, run_time, prio
   localparam int REQ_W = ID_W + RT_W + PRIO_W;
   // response word: slot, ident, wait_time, runtime_left, prio_now,
   // finished, ran, idle, table_full
   localparam int RSP_W = SLOT_W + ID_W + WAIT_W + RT_W + PRIO_W + 4;

   localparam int RSP_FIN_BIT  = SLOT_W + ID_W + WAIT_W + RT_W + PRIO_W;
   localparam int RSP_RAN_BIT  = RSP_FIN_BIT + 1;
   localparam int RSP_IDLE_BIT = RSP_FIN_BIT + 2;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

   typedef struct packed {
      logic clear;
      logic valid;
   } dps_acc_ctrl_type;

endpackage

`default_nettype wire

### sv/dps_wait_unit.sv
// Shared multiply-accumulate unit for the waiting-time sums.
`default_nettype none

module dps_wait_unit import dps_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dps_acc_ctrl_type         ctrl,
   input  logic                     eligible,
   input  logic signed [PRIO_W-1:0] prio_s,
   input  logic signed [PRIO_W-1:0] prio_p,
   input  logic [RT_W-1:0]          rem_s,
   output logic                     busy,
   output logic [WAIT_W-1:0]        wait_sat
);

   localparam int ACC_W = 35 + $clog2(MAX_PROCS);

   logic signed [PRIO_W:0]   diff;
   logic signed [PRIO_W+1:0] fac_a;
   logic signed [PRIO_W+1:0] fac_b;
   logic signed [2*PRIO_W+3:0] prod;
   logic signed [2*PRIO_W+2:0] term_in;
   logic signed [2*PRIO_W+2:0] term_ff;
   logic                       term_v_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;

   // term = (d+1)*rem - d*(d+1)/2 = (d+1)*(2*rem - d)/2, product always even
   always_comb begin
      diff    = {prio_s[PRIO_W-1], prio_s} - {prio_p[PRIO_W-1], prio_p};
      fac_a   = {diff[PRIO_W], diff} + 18'sd1;
      fac_b   = $signed({1'b0, rem_s, 1'b0}) - {diff[PRIO_W], diff};
      prod    = fac_a * fac_b;
      term_in = eligible ? prod[2*PRIO_W+3:1] : '0;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (term_v_ff) begin
         acc_in = acc_ff + {{(ACC_W-(2*PRIO_W+3)){term_ff[2*PRIO_W+2]}}, term_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_v_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         term_v_ff <= ctrl.valid && !ctrl.clear;
         acc_ff    <= acc_in;
      end
      term_ff <= term_in;
   end

   always_comb begin
      busy = term_v_ff;
      if (acc_ff[ACC_W-1]) begin
         wait_sat = '0;
      end else if (|acc_ff[ACC_W-2:WAIT_W]) begin
         wait_sat = '1;
      end else begin
         wait_sat = acc_ff[WAIT_W-1:0];
      end
   end

endmodule

`default_nettype wire

### sv/dynamic_priority_scheduler.sv
// Top level of the dynamic priority scheduler: sequencer, entry stores, output register.
//
// An add word (tuser = 0) stores a process in the next free slot, or flags table_full
// when the table is full, and returns one acknowledgement word on the next cycle. A tick
// word (tuser = 1) computes each entry's waiting time by sweeping every pair of entries
// through one shared multiplier, picks the best live entry and runs it if it has runtime
// left, then returns one word per entry, newest first, tlast on the slot 0 word; on an
// empty table it returns one idle word. The length of a tick is set by the pair sweep
// (one pair per cycle plus a setup and drain per entry) and by the report, in which each
// word first reads the entry store and then loads the output register. req_tready is low
// while a word is at work or a response is still waiting to be taken.
`default_nettype none

module dynamic_priority_scheduler import dps_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // proc_id, run_time, prio
   input  logic             req_tuser,  // op
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // slot, ident, wait_time, runtime_left,
                                        // prio_now, finished, ran, idle, table_full
   output logic             rsp_tuser,  // entry_valid
   output logic             rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_PROCS);
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PRD   = 4'd1;
   localparam logic [3:0] ST_PCAP  = 4'd2;
   localparam logic [3:0] ST_PAIR  = 4'd3;
   localparam logic [3:0] ST_WWR   = 4'd4;
   localparam logic [3:0] ST_RUNRD = 4'd5;
   localparam logic [3:0] ST_RUNWR = 4'd6;
   localparam logic [3:0] ST_RPRD  = 4'd7;
   localparam logic [3:0] ST_RPOUT = 4'd8;

   function automatic logic [RSP_W-1:0] rsp_word(
      input logic [SLOT_W-1:0]        slot,
      input logic [ID_W-1:0]          ident,
      input logic [WAIT_W-1:0]        wt,
      input logic [RT_W-1:0]          rt,
      input logic signed [PRIO_W-1:0] pr,
      input logic                     fin,
      input logic                     ran,
      input logic                     idle,
      input logic                     full
   );
      rsp_word = {full, idle, ran, fin, pr, rt, wt, ident, slot};
   endfunction

   // request fields
   logic [ID_W-1:0]          req_id;
   logic [RT_W-1:0]          req_rt;
   logic signed [PRIO_W-1:0] req_prio;

   // sequencer state
   logic [3:0]               st_ff, st_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         p_ff, p_in;
   logic [CNT_W-1:0]         s_ff, s_in;
   logic [IDX_W-1:0]         s1_ff;
   logic                     v1_ff;
   logic [IDX_W-1:0]         e_ff, e_in;
   logic [IDX_W-1:0]         pick_ff, pick_in;
   logic                     found_ff, found_in;
   logic signed [PRIO_W-1:0] best_ff, best_in;
   logic signed [PRIO_W-1:0] prio_p_ff, prio_p_in;
   logic                     idle_ff, idle_in;
   logic [MAX_PROCS-1:0]     ended_ff, ended_in;

   // output register
   logic [RSP_W-1:0]         rsp_tdata_ff;
   logic                     rsp_tuser_ff, rsp_tlast_ff, rsp_tvalid_ff;
   logic                     out_load;
   logic [RSP_W-1:0]         out_data;
   logic                     out_user, out_last;

   // entry stores
   logic [ID_W-1:0]          ids_mem  [MAX_PROCS];
   logic [RT_W-1:0]          rem_mem  [MAX_PROCS];
   logic signed [PRIO_W-1:0] prio_mem [MAX_PROCS];
   logic [WAIT_W-1:0]        wait_mem [MAX_PROCS];
   logic [ID_W-1:0]          ids_rd_ff;
   logic [RT_W-1:0]          rem_rd_ff;
   logic signed [PRIO_W-1:0] prio_rd_ff;
   logic [WAIT_W-1:0]        wait_rd_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     add_we, ent_we, wait_we;
   logic [IDX_W-1:0]         ent_waddr;
   logic [RT_W-1:0]          rem_wdata;
   logic signed [PRIO_W-1:0] prio_wdata;
   logic [WAIT_W-1:0]        wait_wdata;

   logic                     req_fire, out_free, issue, run_idle;
   logic [CNT_W-1:0]         p_next;
   dps_acc_ctrl_type         acc_ctrl;
   logic                     acc_busy, eligible;
   logic [WAIT_W-1:0]        wait_sat;

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_rt   = req_tdata[ID_W+RT_W-1:ID_W];
   assign req_prio = req_tdata[REQ_W-1:ID_W+RT_W];

   assign req_tready = (st_ff == ST_IDLE) && !rsp_tvalid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign issue      = (st_ff == ST_PAIR) && (s_ff < cnt_ff);
   assign p_next     = p_ff + CNT_W'(1);
   assign run_idle   = !found_ff || (rem_rd_ff == '0);

   assign eligible = (s1_ff != p_ff[IDX_W-1:0]) && !ended_ff[s1_ff]
                     && (prio_rd_ff >= prio_p_ff);
   assign acc_ctrl.clear = (st_ff == ST_PCAP);
   assign acc_ctrl.valid = v1_ff;

   dps_wait_unit #(
      .MAX_PROCS (MAX_PROCS)
   ) u_wait (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (acc_ctrl),
      .eligible (eligible),
      .prio_s   (prio_rd_ff),
      .prio_p   (prio_p_ff),
      .rem_s    (rem_rd_ff),
      .busy     (acc_busy),
      .wait_sat (wait_sat)
   );

   always_comb begin
      unique case (st_ff)
         ST_PRD:            rd_addr = p_ff[IDX_W-1:0];
         ST_PAIR:           rd_addr = s_ff[IDX_W-1:0];
         ST_RUNRD:          rd_addr = pick_ff;
         ST_RPRD, ST_RPOUT: rd_addr = e_ff;
         default:           rd_addr = p_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      p_in       = p_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      pick_in    = pick_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      prio_p_in  = prio_p_ff;
      idle_in    = idle_ff;
      ended_in   = ended_ff;
      out_load   = 1'b0;
      out_data   = '0;
      out_user   = 1'b0;
      out_last   = 1'b0;
      add_we     = 1'b0;
      ent_we     = 1'b0;
      ent_waddr  = cnt_ff[IDX_W-1:0];
      rem_wdata  = req_rt;
      prio_wdata = req_prio;
      wait_we    = 1'b0;
      wait_wdata = ended_ff[p_ff[IDX_W-1:0]] ? '0 : wait_sat;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               out_load = 1'b1;
               out_last = 1'b1;
               if (req_tuser == OP_ADD) begin
                  if (cnt_ff == CNT_W'(MAX_PROCS)) begin
                     out_data = rsp_word('0, req_id, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                  end else begin
                     add_we   = 1'b1;
                     ent_we   = 1'b1;
                     ended_in[cnt_ff[IDX_W-1:0]] = 1'b0;
                     cnt_in   = cnt_ff + CNT_W'(1);
                     out_data = rsp_word(SLOT_W'(cnt_ff), req_id, '0, req_rt, req_prio,
                                         1'b0, 1'b0, 1'b0, 1'b0);
                  end
               end else if (cnt_ff == '0) begin
                  out_data = rsp_word('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
               end else begin
                  out_load = 1'b0;
                  p_in     = '0;
                  found_in = 1'b0;
                  st_in    = ST_PRD;
               end
            end
         end
         ST_PRD: begin
            st_in = ST_PCAP;
         end
         ST_PCAP: begin
            prio_p_in = prio_rd_ff;
            s_in      = '0;
            if (!ended_ff[p_ff[IDX_W-1:0]] && (!found_ff || prio_rd_ff > best_ff)) begin
               pick_in  = p_ff[IDX_W-1:0];
               best_in  = prio_rd_ff;
               found_in = 1'b1;
            end
            st_in = ST_PAIR;
         end
         ST_PAIR: begin
            if (issue) begin
               s_in = s_ff + CNT_W'(1);
            end else if (!v1_ff && !acc_busy) begin
               st_in = ST_WWR;
            end
         end
         ST_WWR: begin
            wait_we = 1'b1;
            p_in    = p_next;
            st_in   = (p_next == cnt_ff) ? ST_RUNRD : ST_PRD;
         end
         ST_RUNRD: begin
            st_in = ST_RUNWR;
         end
         ST_RUNWR: begin
            idle_in    = run_idle;
            ent_we     = !run_idle;
            ent_waddr  = pick_ff;
            rem_wdata  = rem_rd_ff - RT_W'(1);
            prio_wdata = (prio_rd_ff == PRIO_MIN) ? prio_rd_ff : prio_rd_ff - PRIO_W'(1);
            e_in       = IDX_W'(cnt_ff - CNT_W'(1));
            st_in      = ST_RPRD;
         end
         ST_RPRD: begin
            st_in = ST_RPOUT;
         end
         ST_RPOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_user = 1'b1;
               out_last = (e_ff == '0);
               out_data = rsp_word(SLOT_W'(e_ff), ids_rd_ff, wait_rd_ff, rem_rd_ff,
                                   prio_rd_ff, ended_ff[e_ff],
                                   !idle_ff && (e_ff == pick_ff), idle_ff, 1'b0);
               // finished marking is safe per word: later words never read this bit
               if (rem_rd_ff == '0) begin
                  ended_in[e_ff] = 1'b1;
               end
               if (e_ff == '0) begin
                  st_in = ST_IDLE;
               end else begin
                  e_in  = e_ff - IDX_W'(1);
                  st_in = ST_RPRD;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         cnt_ff   <= '0;
         ended_ff <= '0;
         v1_ff    <= 1'b0;
         found_ff <= 1'b0;
         idle_ff  <= 1'b0;
         p_ff     <= '0;
         s_ff     <= '0;
         e_ff     <= '0;
         pick_ff  <= '0;
      end else begin
         st_ff    <= st_in;
         cnt_ff   <= cnt_in;
         ended_ff <= ended_in;
         v1_ff    <= issue;
         found_ff <= found_in;
         idle_ff  <= idle_in;
         p_ff     <= p_in;
         s_ff     <= s_in;
         e_ff     <= e_in;
         pick_ff  <= pick_in;
      end
      s1_ff     <= s_ff[IDX_W-1:0];
      best_ff   <= best_in;
      prio_p_ff <= prio_p_in;
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         ids_mem[cnt_ff[IDX_W-1:0]] <= req_id;
      end
      if (ent_we) begin
         rem_mem[ent_waddr]  <= rem_wdata;
         prio_mem[ent_waddr] <= prio_wdata;
      end
      if (wait_we) begin
         wait_mem[p_ff[IDX_W-1:0]] <= wait_wdata;
      end
      ids_rd_ff  <= ids_mem[rd_addr];
      rem_rd_ff  <= rem_mem[rd_addr];
      prio_rd_ff <= prio_mem[rd_addr];
      wait_rd_ff <= wait_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_tdata_ff <= out_data;
         rsp_tuser_ff <= out_user;
         rsp_tlast_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PROCS))
      else $error("entry count beyond table size");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_TICK && cnt_ff != '0) |=> st_ff == ST_PRD)
      else $error("tick did not start the wait sweep");

   a_report_end: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RPOUT && out_free && e_ff == '0)
      |=> (rsp_tvalid_ff && rsp_tlast_ff && st_ff == ST_IDLE))
      else $error("slot 0 report not closing the tick");

   a_ran_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[RSP_RAN_BIT]) |-> !rsp_tdata_ff[RSP_IDLE_BIT])
      else $error("entry reported as run on an idle tick");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the dynamic priority scheduler with scoreboard and random stalls.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dps_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int FILL_MARK    = 13;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;

   localparam int OFS_ID        = SLOT_W;
   localparam int OFS_WAIT      = OFS_ID + ID_W;
   localparam int OFS_RT        = OFS_WAIT + WAIT_W;
   localparam int OFS_PRIO      = OFS_RT + RT_W;
   localparam int RSP_FULL_BIT  = RSP_IDLE_BIT + 1;

   localparam logic [RT_W-1:0]   RT_MAX   = '1;
   localparam logic [PRIO_W-1:0] PRIO_TOP = ~PRIO_MIN;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   ident;
      logic [WAIT_W-1:0] wait_time;
      logic [RT_W-1:0]   runtime_left;
      logic [PRIO_W-1:0] prio_now;
      logic              finished;
      logic              ran;
      logic              idle;
      logic              table_full;
      logic              entry_valid;
      logic              last;
   } sched_word_type;

   class sched_model_type;
      int entries;
      int errors;
      logic [ID_W-1:0] ids [TABLE_DEPTH];
      int left [TABLE_DEPTH];
      int prio [TABLE_DEPTH];
      bit done [TABLE_DEPTH];
      sched_word_type expected_words[$];

      function new();
         entries = 0;
         errors  = 0;
         foreach (done[i]) done[i] = 1'b0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // sum over live entries at or above p's priority, clamped to 32 bits
      function logic [WAIT_W-1:0] waiting_time(int p);
         longint sum = 0;
         longint d;
         for (int s = 0; s < entries; s++) begin
            if (s != p && !done[s] && prio[s] >= prio[p]) begin
               d = longint'(prio[s]) - longint'(prio[p]);
               sum += (d + 1) * longint'(left[s]) - (d * (d + 1)) / 2;
            end
         end
         if (sum < 0) return '0;
         if (sum > 64'sh0000_0000_FFFF_FFFF) return '1;
         return sum[WAIT_W-1:0];
      endfunction

      function void note_request(logic op, logic [REQ_W-1:0] data);
         logic [ID_W-1:0]   pid;
         logic [RT_W-1:0]   rt;
         logic [PRIO_W-1:0] pr;
         logic [WAIT_W-1:0] waits [TABLE_DEPTH];
         sched_word_type w;
         int pick;
         bit found;
         bit idle;
         pid = data[0 +: ID_W];
         rt  = data[ID_W +: RT_W];
         pr  = data[ID_W + RT_W +: PRIO_W];
         w = '0;
         w.last = 1'b1;
         if (op == OP_ADD) begin
            w.ident = pid;
            if (entries >= TABLE_DEPTH) begin
               w.table_full = 1'b1;
            end else begin
               ids[entries]  = pid;
               left[entries] = rt;
               prio[entries] = int'(signed'(pr));
               done[entries] = 1'b0;
               w.slot         = entries[SLOT_W-1:0];
               w.runtime_left = rt;
               w.prio_now     = pr;
               entries++;
            end
            expected_words.push_back(w);
            return;
         end
         if (entries == 0) begin
            w.idle = 1'b1;
            expected_words.push_back(w);
            return;
         end
         for (int i = 0; i < entries; i++)
            waits[i] = done[i] ? '0 : waiting_time(i);
         found = 1'b0;
         pick  = 0;
         for (int i = 0; i < entries; i++) begin
            if (!done[i] && (!found || prio[i] > prio[pick])) begin
               pick  = i;
               found = 1'b1;
            end
         end
         idle = !found || left[pick] == 0;
         if (!idle) begin
            left[pick]--;
            if (prio[pick] > int'(PRIO_MIN)) prio[pick]--;
         end
         // newest first; finished flag is the one from before this tick
         for (int e = entries - 1; e >= 0; e--) begin
            w = '0;
            w.slot         = e[SLOT_W-1:0];
            w.ident        = ids[e];
            w.wait_time    = waits[e];
            w.runtime_left = left[e][RT_W-1:0];
            w.prio_now     = prio[e][PRIO_W-1:0];
            w.finished     = done[e];
            w.ran          = !idle && e == pick;
            w.idle         = idle;
            w.entry_valid  = 1'b1;
            w.last         = e == 0;
            expected_words.push_back(w);
         end
         for (int i = 0; i < entries; i++)
            if (left[i] == 0) done[i] = 1'b1;
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [RSP_W-1:0] data, logic entry_valid, logic last);
         sched_word_type want;
         if (expected_words.size() == 0) begin
            $error("response word with nothing expected: %h", data);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         check_field("slot", want.slot, data[0 +: SLOT_W]);
         check_field("ident", want.ident, data[OFS_ID +: ID_W]);
         check_field("wait_time", want.wait_time, data[OFS_WAIT +: WAIT_W]);
         check_field("runtime_left", want.runtime_left, data[OFS_RT +: RT_W]);
         check_field("prio_now", want.prio_now, data[OFS_PRIO +: PRIO_W]);
         check_field("finished", want.finished, data[RSP_FIN_BIT]);
         check_field("ran", want.ran, data[RSP_RAN_BIT]);
         check_field("idle", want.idle, data[RSP_IDLE_BIT]);
         check_field("table_full", want.table_full, data[RSP_FULL_BIT]);
         check_field("entry_valid", want.entry_valid, entry_valid);
         check_field("last", want.last, last);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   sched_model_type sb;
   bit send_calm = 1'b0;
   bit rsp_calm  = 1'b0;
   int stall_left = 0;
   int quiet = 0;

   dynamic_priority_scheduler #(.MAX_PROCS(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: check every accepted word, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ($urandom_range(0, 199) == 0) rsp_calm <= !rsp_calm;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 40);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
   end

   initial begin
      wait (quiet >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   function automatic int sender_gap();
      int r;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      if (send_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(logic op, logic [REQ_W-1:0] data);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, data);
   endtask

   task automatic add_proc(logic [ID_W-1:0] id, logic [RT_W-1:0] rt, logic [PRIO_W-1:0] pr);
      send_word(OP_ADD, {pr, rt, id});
   endtask

   task automatic random_add();
      logic [RT_W-1:0]   rt;
      logic [PRIO_W-1:0] pr;
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)      rt = '0;
      else if (r < 75) rt = RT_W'($urandom_range(1, 6));
      else if (r < 85) rt = RT_W'($urandom_range(1, 40));
      else             rt = RT_W'($urandom());
      // wide priority only with short runtimes, so nothing hogs the table
      if (rt > 40 || $urandom_range(0, 3) != 0) pr = PRIO_W'($urandom_range(0, 16) - 8);
      else                                      pr = PRIO_W'($urandom());
      add_proc(ID_W'($urandom()), rt, pr);
   endtask

   task automatic random_tick();
      send_word(OP_TICK, REQ_W'({$urandom(), $urandom()}));
   endtask

   // hold the sender until every expected word has come back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_TICK, '0);                  // empty table
      add_proc(8'h00, 16'd1, PRIO_MIN);
      random_tick();                           // runs at the priority floor
      random_tick();                           // everything finished
      add_proc(8'hFF, 16'd0, PRIO_TOP);        // chosen with no runtime left
      add_proc(8'h5A, RT_MAX, PRIO_MIN);       // negative wait clamps to zero
      random_tick();
      add_proc(8'h33, 16'd3, 16'd5);
      add_proc(8'hC3, 16'd2, 16'd5);
      random_tick();                           // tie, oldest wins
      random_tick();
      send_word(OP_TICK, '1);
      hold_until_drained();

      repeat (160) begin
         if (sb.entries < FILL_MARK && $urandom_range(0, 99) < 35) random_add();
         else random_tick();
      end
      hold_until_drained();

      while (sb.entries < FILL_MARK) random_add();
      // long high-priority jobs push low waits into saturation
      repeat (TABLE_DEPTH - FILL_MARK) add_proc(ID_W'($urandom()), RT_MAX, PRIO_TOP);
      repeat (30) begin
         if ($urandom_range(0, 99) < 30) random_add();
         else random_tick();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

### sim.f
sv/dps_pkg.sv
sv/dps_wait_unit.sv
sv/dynamic_priority_scheduler.sv
tb/sv/tb.sv
